// ----- design/cat_cls_pkg.sv -----
// shared types, constants and code table for the control command classifier
package cat_cls_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned BODY_W     = 12;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CODE_COUNT = 15;

  localparam logic [CHAR_W-1:0] TERMINATOR = 8'h3B;
  localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_GAP   = 8'h20;
  localparam logic [BODY_W-1:0] BODY_MAX   = 12'd4095;

  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
    logic [LEN_W-1:0]  query_len;
    logic [LEN_W-1:0]  set_len;
  } code_entry_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_index;
    logic [KIND_W-1:0] request_kind;
  } class_result_t;

  // zero length means the form does not exist
  localparam code_entry_t CODE_TABLE [CODE_COUNT] = '{
    '{8'h41, 8'h47, 4'd3, 4'd6},
    '{8'h42, 8'h43, 4'd2, 4'd3},
    '{8'h46, 8'h41, 4'd2, 4'd13},
    '{8'h47, 8'h54, 4'd2, 4'd5},
    '{8'h49, 8'h46, 4'd2, 4'd0},
    '{8'h4D, 8'h44, 4'd2, 4'd3},
    '{8'h4E, 8'h42, 4'd2, 4'd3},
    '{8'h4E, 8'h52, 4'd2, 4'd3},
    '{8'h50, 8'h43, 4'd2, 4'd5},
    '{8'h50, 8'h52, 4'd2, 4'd3},
    '{8'h52, 8'h47, 4'd2, 4'd5},
    '{8'h52, 8'h58, 4'd0, 4'd2},
    '{8'h53, 8'h51, 4'd3, 4'd6},
    '{8'h54, 8'h58, 4'd0, 4'd2},
    '{8'h56, 8'h58, 4'd2, 4'd3}
  };

  function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ----- design/cat_cls_match.sv -----
// code table compare and body length check for one finished message
module cat_cls_match
  import cat_cls_pkg::*;
(
  input  logic [CHAR_W-1:0] first_char,
  input  logic [CHAR_W-1:0] second_char,
  input  logic [BODY_W-1:0] byte_count,
  output class_result_t     result
);

  logic [CHAR_W-1:0]     u0;
  logic [CHAR_W-1:0]     u1;
  logic [CODE_COUNT-1:0] hit;

  assign u0 = fold_upper(first_char);
  assign u1 = fold_upper(second_char);

  always_comb begin
    for (int i = 0; i < CODE_COUNT; i++) begin
      hit[i] = (CODE_TABLE[i].c0 == u0) && (CODE_TABLE[i].c1 == u1);
    end
  end

  // codes are distinct, so at most one entry hits
  always_comb begin
    result.code_index   = '0;
    result.request_kind = KIND_ERROR;
    if (byte_count >= BODY_W'(2)) begin
      for (int i = 0; i < CODE_COUNT; i++) begin
        if (hit[i]) begin
          if (CODE_TABLE[i].query_len != '0 &&
              byte_count == BODY_W'(CODE_TABLE[i].query_len)) begin
            result.code_index   = CODE_W'(i);
            result.request_kind = KIND_QUERY;
          end else if (CODE_TABLE[i].set_len != '0 &&
                       byte_count == BODY_W'(CODE_TABLE[i].set_len)) begin
            result.code_index   = CODE_W'(i);
            result.request_kind = KIND_SET;
          end
        end
      end
    end
  end

endmodule

// ----- design/cat_command_classifier_unit.sv -----
// top level of the control command classifier: input register, message state, result register
//
// The input channel (in_valid, in_stall, in_rx_byte) carries one character
// of the control stream per transaction. Characters are collected into a
// message: the first two are kept and the body is counted up to the first
// zero byte, saturating at the smaller of MAX_MESSAGE and 4095. A ';'
// character closes the message and produces one result transaction on the
// output channel (out_valid, out_stall, out_code_index, out_request_kind,
// out_body_length); other characters produce none.
// A ';' is accepted into the input register, and its result is then loaded into
// the result register, which presents it on the output channel.
// Throughput: one character per cycle through the single input register, unless
// a ';' must wait there while a stalled result is held.
// When the receiver stalls, the result register holds its transaction; a
// further ';' then waits in the input register and in_stall rises, while
// ordinary characters keep flowing. Reset clears both valid flags and the
// message state, so the first character after reset starts a new message.
module cat_command_classifier_unit
  import cat_cls_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE = 4095
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_code_index,
  output logic [KIND_W-1:0] out_request_kind,
  output logic [BODY_W-1:0] out_body_length
);

  localparam logic [BODY_W-1:0] COUNT_LIMIT =
    (MAX_MESSAGE < 4095) ? BODY_W'(MAX_MESSAGE) : BODY_MAX;

  logic              in_valid_r, in_valid_nxt;
  logic [CHAR_W-1:0] in_byte_r, in_byte_nxt;
  logic [CHAR_W-1:0] first_char_r, first_char_nxt;
  logic [CHAR_W-1:0] second_char_r, second_char_nxt;
  logic [BODY_W-1:0] byte_count_r, byte_count_nxt;
  logic              zero_seen_r, zero_seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [BODY_W-1:0] out_len_r, out_len_nxt;

  logic          is_term;
  logic          out_free;
  logic          advance;
  class_result_t match_res;

  cat_cls_match u_match (
    .first_char  (first_char_r),
    .second_char (second_char_r),
    .byte_count  (byte_count_r),
    .result      (match_res)
  );

  assign is_term  = (in_byte_r == TERMINATOR);
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && (!is_term || out_free);
  assign in_stall = in_valid_r && !advance;

  always_comb begin
    in_valid_nxt    = in_valid_r;
    in_byte_nxt     = in_byte_r;
    first_char_nxt  = first_char_r;
    second_char_nxt = second_char_r;
    byte_count_nxt  = byte_count_r;
    zero_seen_nxt   = zero_seen_r;
    out_valid_nxt   = out_stall ? out_valid_r : 1'b0;
    out_code_nxt    = out_code_r;
    out_kind_nxt    = out_kind_r;
    out_len_nxt     = out_len_r;

    if (!in_stall) begin
      in_valid_nxt = in_valid;
      if (in_valid) begin
        in_byte_nxt = in_rx_byte;
      end
    end

    if (advance) begin
      if (is_term) begin
        out_valid_nxt   = 1'b1;
        out_code_nxt    = match_res.code_index;
        out_kind_nxt    = match_res.request_kind;
        out_len_nxt     = byte_count_r;
        first_char_nxt  = '0;
        second_char_nxt = '0;
        byte_count_nxt  = '0;
        zero_seen_nxt   = 1'b0;
      end else if (in_byte_r == '0) begin
        zero_seen_nxt = 1'b1;
      end else if (!zero_seen_r && byte_count_r < COUNT_LIMIT) begin
        if (byte_count_r == '0) begin
          first_char_nxt = in_byte_r;
        end else if (byte_count_r == BODY_W'(1)) begin
          second_char_nxt = in_byte_r;
        end
        byte_count_nxt = byte_count_r + BODY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      first_char_r  <= '0;
      second_char_r <= '0;
      byte_count_r  <= '0;
      zero_seen_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      in_valid_r    <= in_valid_nxt;
      first_char_r  <= first_char_nxt;
      second_char_r <= second_char_nxt;
      byte_count_r  <= byte_count_nxt;
      zero_seen_r   <= zero_seen_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r  <= in_byte_nxt;
    out_code_r <= out_code_nxt;
    out_kind_r <= out_kind_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_code_index   = out_code_r;
  assign out_request_kind = out_kind_r;
  assign out_body_length  = out_len_r;

endmodule
